// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgtsr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgtsr assertion failed");

`endif

// ===== rtl/core/bgtsr_pkg.sv =====
// Shared constants, types and a function of the background scanline renderer.
package bgtsr_pkg;

   localparam int VMEM_DEPTH = 8192;
   localparam int VMEM_AW = 13;
   localparam int DATA_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int GROUP_IDX_W = 5;
   localparam int PIXELS_PER_LINE_DEF = 160;

   localparam logic [VMEM_AW-1:0] MAP_LOW = 13'h1800;
   localparam logic [VMEM_AW-1:0] MAP_HIGH = 13'h1C00;

   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_Y = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_X = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_SELECT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_PALETTE = 2'd3;

   localparam logic [DATA_W-1:0] PALETTE_RESET = 8'd228;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   typedef struct packed {
      logic clear_wr;
      logic req_write;
      logic load_render;
      logic rd_map;
      logic shift_tile;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic tile_last;
   } ctl_status_type;

   function automatic logic [1:0] shade_of(input logic [7:0] palette,
                                           input logic [1:0] colour);
      return palette[{colour, 1'b0} +: 2];
   endfunction

endpackage

// ===== rtl/core/bgtsr_ctrl.sv =====
// Controller state machine: memory clearing pass, request acceptance and tile fetch sequence.
module bgtsr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_type,
   input  bgtsr_pkg::ctl_status_type status,
   output logic                      busy,
   output bgtsr_pkg::ctl_cmd_type    cmd
);
   import bgtsr_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_MAP = 3'd2;
   localparam logic [2:0] ST_TILE = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   always_comb begin
      accept = start && (state_ff == ST_IDLE);
      busy = (state_ff != ST_IDLE);
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_WRITE) begin
                  cmd.req_write = 1'b1;
               end else begin
                  cmd.load_render = 1'b1;
                  state_in = ST_MAP;
               end
            end
         end
         ST_MAP: begin
            cmd.rd_map = 1'b1;
            state_in = ST_TILE;
         end
         ST_TILE: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.shift_tile = 1'b1;
            state_in = status.tile_last ? ST_IDLE : ST_MAP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/bgtsr_datapath.sv =====
// Datapath: video memory, control registers, tile fetch addressing and pixel group assembly.
module bgtsr_datapath #(
   parameter int PIXELS_PER_LINE = bgtsr_pkg::PIXELS_PER_LINE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bgtsr_pkg::ctl_cmd_type                cmd,
   output bgtsr_pkg::ctl_status_type             status,
   input  logic                                  csr_wr_en,
   input  logic [bgtsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bgtsr_pkg::DATA_W-1:0]          csr_wr_data,
   input  logic [bgtsr_pkg::VMEM_AW-1:0]         req_address,
   input  logic [bgtsr_pkg::DATA_W-1:0]          req_write_data,
   input  logic [7:0]                            req_line_number,
   output logic                                  rsp_valid,
   output logic [bgtsr_pkg::GROUP_IDX_W-1:0]     rsp_group_index,
   output logic [15:0]                           rsp_pixel_shades,
   output logic                                  rsp_last_group
);
   import bgtsr_pkg::*;

   localparam int GROUPS = PIXELS_PER_LINE / 8;
   localparam int TILE_W = $clog2(GROUPS + 1);

   logic [DATA_W-1:0]  vmem [VMEM_DEPTH];
   logic [DATA_W-1:0]  rd_a_ff;
   logic [DATA_W-1:0]  rd_b_ff;

   logic [7:0]         scroll_y_ff;
   logic [7:0]         scroll_x_ff;
   logic               map_select_ff;
   logic [7:0]         bg_palette_ff;

   logic [VMEM_AW-1:0] clr_addr_ff;
   logic [7:0]         row_ff;
   logic [TILE_W-1:0]  tile_cnt_ff;
   logic [DATA_W-1:0]  prev_lo_ff;
   logic [DATA_W-1:0]  prev_hi_ff;

   logic               rsp_valid_ff;
   logic [GROUP_IDX_W-1:0] rsp_group_index_ff;
   logic [15:0]        rsp_pixel_shades_ff;
   logic               rsp_last_group_ff;

   logic               mem_we;
   logic [VMEM_AW-1:0] mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [4:0]         tile_col;
   logic [VMEM_AW-1:0] map_base;
   logic [VMEM_AW-1:0] map_addr;
   logic [VMEM_AW-1:0] tile_addr;
   logic [VMEM_AW-1:0] rd_a_addr;
   logic [VMEM_AW-1:0] rd_b_addr;
   logic [15:0]        lo_win;
   logic [15:0]        hi_win;
   logic [15:0]        shades;
   logic               emit;

   always_comb begin
      mem_we = cmd.clear_wr || cmd.req_write;
      mem_waddr = cmd.clear_wr ? clr_addr_ff : req_address;
      mem_wdata = cmd.clear_wr ? '0 : req_write_data;

      tile_col = scroll_x_ff[7:3] + 5'(tile_cnt_ff);
      map_base = map_select_ff ? MAP_HIGH : MAP_LOW;
      map_addr = map_base + VMEM_AW'({row_ff[7:3], tile_col});
      tile_addr = VMEM_AW'({rd_a_ff, row_ff[2:0], 1'b0});
      rd_a_addr = cmd.rd_map ? map_addr : tile_addr;
      rd_b_addr = tile_addr | VMEM_AW'(1);

      lo_win = {prev_lo_ff, rd_a_ff} << scroll_x_ff[2:0];
      hi_win = {prev_hi_ff, rd_b_ff} << scroll_x_ff[2:0];
      for (int p = 0; p < 8; p++) begin
         shades[15 - 2 * p -: 2] = shade_of(bg_palette_ff, {hi_win[15 - p], lo_win[15 - p]});
      end

      emit = cmd.shift_tile && (tile_cnt_ff != '0);
      status.clear_last = (clr_addr_ff == {VMEM_AW{1'b1}});
      status.tile_last = (tile_cnt_ff == TILE_W'(GROUPS));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= vmem[rd_a_addr];
      rd_b_ff <= vmem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_y_ff <= '0;
         scroll_x_ff <= '0;
         map_select_ff <= 1'b0;
         bg_palette_ff <= PALETTE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCROLL_Y: scroll_y_ff <= csr_wr_data;
            CSR_SCROLL_X: scroll_x_ff <= csr_wr_data;
            CSR_MAP_SELECT: map_select_ff <= csr_wr_data[0];
            CSR_BG_PALETTE: bg_palette_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         tile_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + VMEM_AW'(1);
         end
         if (cmd.load_render) begin
            tile_cnt_ff <= '0;
         end else if (cmd.shift_tile) begin
            tile_cnt_ff <= tile_cnt_ff + TILE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_render) begin
         row_ff <= req_line_number + scroll_y_ff;
      end
      if (cmd.shift_tile) begin
         prev_lo_ff <= rd_a_ff;
         prev_hi_ff <= rd_b_ff;
      end
      if (emit) begin
         rsp_group_index_ff <= GROUP_IDX_W'(tile_cnt_ff - TILE_W'(1));
         rsp_pixel_shades_ff <= shades;
         rsp_last_group_ff <= status.tile_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_group_index = rsp_group_index_ff;
   assign rsp_pixel_shades = rsp_pixel_shades_ff;
   assign rsp_last_group = rsp_last_group_ff;

endmodule

// ===== rtl/core/bg_tile_scanline_renderer.sv =====
// Top level of the background tile-map scanline renderer.
// A request with start high is taken when busy is low. A video memory write keeps busy low.
// For a line render, each tile column costs a map read, then the two bit-plane reads, one
// on each of the memory's two read ports, then an assembly step, and one extra tile is
// fetched for the horizontal fine scroll. Results come as one-cycle strobes on rsp_valid,
// and the receiver cannot stall them. After reset the 8192-byte video memory is cleared one
// byte a cycle, so busy stays high until the clearing pass ends; register writes are taken
// during that time.
module bg_tile_scanline_renderer #(
   parameter int PIXELS_PER_LINE = bgtsr_pkg::PIXELS_PER_LINE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [bgtsr_pkg::VMEM_AW-1:0]     req_address,
   input  logic [bgtsr_pkg::DATA_W-1:0]      req_write_data,
   input  logic [7:0]                        req_line_number,
   output logic                              rsp_valid,
   output logic [bgtsr_pkg::GROUP_IDX_W-1:0] rsp_group_index,
   output logic [15:0]                       rsp_pixel_shades,
   output logic                              rsp_last_group,
   input  logic                              csr_wr_en,
   input  logic [bgtsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bgtsr_pkg::DATA_W-1:0]      csr_wr_data
);
   import bgtsr_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   bgtsr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   bgtsr_datapath #(
      .PIXELS_PER_LINE (PIXELS_PER_LINE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_line_number  (req_line_number),
      .rsp_valid        (rsp_valid),
      .rsp_group_index  (rsp_group_index),
      .rsp_pixel_shades (rsp_pixel_shades),
      .rsp_last_group   (rsp_last_group)
   );

endmodule

// ===== rtl/core/bgtsr_checker.sv =====
// Port-level assertion checker for the scanline renderer, with its bind statement.
`include "assert_macros.svh"

module bgtsr_checker #(
   parameter int PIXELS_PER_LINE = bgtsr_pkg::PIXELS_PER_LINE_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [bgtsr_pkg::GROUP_IDX_W-1:0] rsp_group_index,
   input logic                              rsp_last_group
);
   import bgtsr_pkg::*;

   localparam logic [GROUP_IDX_W-1:0] LAST_IDX = GROUP_IDX_W'(PIXELS_PER_LINE / 8 - 1);

   // The memory clearing pass keeps the block busy right after reset.
   `ASSERT_IMPL(a_busy_after_reset, clock, reset, $past(reset), busy)

   // Only the final group of a line can appear once the block is idle again.
   `ASSERT_IMPL(a_mid_line_busy, clock, reset, rsp_valid && !rsp_last_group, busy)

   // The final group carries the highest group index.
   `ASSERT_IMPL(a_last_index, clock, reset, rsp_valid && rsp_last_group,
                rsp_group_index == LAST_IDX)

   // Groups of one line follow each other with indexes rising by one.
   `ASSERT_IMPL(a_group_step, clock, reset,
                rsp_valid && $past(rsp_valid, 3) && !$past(rsp_last_group, 3),
                rsp_group_index == GROUP_IDX_W'($past(rsp_group_index, 3) + 1))

   // Strobes never come back to back.
   `ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_valid, !rsp_valid)

endmodule

bind bg_tile_scanline_renderer bgtsr_checker #(
   .PIXELS_PER_LINE (PIXELS_PER_LINE)
) u_bgtsr_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_group_index (rsp_group_index),
   .rsp_last_group  (rsp_last_group)
);
